@@ rtl/core/qrm_pkg.sv @@
// ----------------------------------------------------------------------------
// qrm_pkg
// Types, constants and arithmetic helpers shared by the quaternion unit:
// word and quaternion types, request and response structs, rounding and
// saturation of products and sums.
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    // four terms of at most one word each fit in two extra bits
    localparam int SUM_BITS  = WORD_BITS + 2;
    localparam int QUAT_PARTS = 4;
    localparam int HAM_TERMS  = QUAT_PARTS * QUAT_PARTS;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [SUM_BITS-1:0]  sum_t;
    // index 0 is the scalar part, then i, j, k
    typedef logic [QUAT_PARTS-1:0][WORD_BITS-1:0] quat_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // sign of term k of component c sits at bit c*4+k; the b part used is c^k
    localparam logic [HAM_TERMS-1:0] HAM_NEG = 16'h428E;

    typedef enum logic {
        CMD_PRODUCT = 1'b0,
        CMD_ROTATE  = 1'b1
    } cmd_e;

    typedef struct packed {
        logic  cmd;
        word_t a_w;
        word_t a_x;
        word_t a_y;
        word_t a_z;
        word_t b_w;
        word_t b_x;
        word_t b_y;
        word_t b_z;
    } req_t;

    typedef struct packed {
        word_t r_w;
        word_t r_x;
        word_t r_y;
        word_t r_z;
    } rsp_t;

    // data carried alongside a product unit
    typedef struct packed {
        logic  cmd;
        quat_t q;
    } side_t;

    // round to nearest (ties upward) and clamp to a word
    function automatic word_t round_sat(input prod_t p);
        logic signed [PROD_BITS:0] t;
        logic signed [PROD_BITS:0] s;
        word_t r;
        t = {p[PROD_BITS-1], p} + ((PROD_BITS+1)'(1) << (FRAC_BITS - 1));
        s = t >>> FRAC_BITS;
        if (s[PROD_BITS:WORD_BITS-1] == '0 || s[PROD_BITS:WORD_BITS-1] == '1)
        begin
            r = s[WORD_BITS-1:0];
        end
        else
        begin
            r = s[PROD_BITS] ? WORD_MIN : WORD_MAX;
        end
        return r;
    endfunction

    // clamp an exact sum to a word
    function automatic word_t sat_sum(input sum_t s);
        word_t r;
        if (s[SUM_BITS-1:WORD_BITS-1] == '0 || s[SUM_BITS-1:WORD_BITS-1] == '1)
        begin
            r = s[WORD_BITS-1:0];
        end
        else
        begin
            r = s[SUM_BITS-1] ? WORD_MIN : WORD_MAX;
        end
        return r;
    endfunction

    // negation with the most negative word going to the largest positive
    function automatic word_t neg_sat(input word_t v);
        word_t r;
        if (v == WORD_MIN)
        begin
            r = WORD_MAX;
        end
        else
        begin
            r = -v;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/qrm_ham.sv @@
// ----------------------------------------------------------------------------
// qrm_ham
// Three-stage Hamilton product unit: sixteen signed multiplies, then
// rounding and clamping of each product, then the signed four-term sums
// with saturation. Side data travels with each request.
// ----------------------------------------------------------------------------
module qrm_ham (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           src_valid,
    output logic           src_stall,
    input  qrm_pkg::quat_t src_a,
    input  qrm_pkg::quat_t src_b,
    input  qrm_pkg::side_t src_side,
    output logic           dst_valid,
    input  logic           dst_stall,
    output qrm_pkg::quat_t dst_q,
    output qrm_pkg::side_t dst_side
);
    import qrm_pkg::*;

    logic  valid1_reg;
    logic  valid2_reg;
    logic  valid3_reg;
    logic  ready1;
    logic  ready2;
    logic  ready3;

    prod_t prod_next [HAM_TERMS];
    prod_t prod_reg  [HAM_TERMS];
    word_t term_reg  [HAM_TERMS];
    quat_t q_next;
    quat_t q_reg;
    side_t side1_reg;
    side_t side2_reg;
    side_t side3_reg;

    // a stage takes a new request when it is empty or its contents move on
    assign ready3    = !valid3_reg || !dst_stall;
    assign ready2    = !valid2_reg || ready3;
    assign ready1    = !valid1_reg || ready2;
    assign src_stall = !ready1;

    // full-width products, term k of component c uses a[k] and b[c^k]
    for (genvar c = 0; c < QUAT_PARTS; c++)
    begin : g_comp
        for (genvar k = 0; k < QUAT_PARTS; k++)
        begin : g_term
            assign prod_next[c*QUAT_PARTS+k] = $signed(src_a[k]) * $signed(src_b[c^k]);
        end
    end

    // signed sums of the rounded terms
    always_comb
    begin
        sum_t acc;
        for (int c = 0; c < QUAT_PARTS; c++)
        begin
            acc = '0;
            for (int k = 0; k < QUAT_PARTS; k++)
            begin
                if (HAM_NEG[c*QUAT_PARTS+k])
                begin
                    acc = acc - sum_t'(term_reg[c*QUAT_PARTS+k]);
                end
                else
                begin
                    acc = acc + sum_t'(term_reg[c*QUAT_PARTS+k]);
                end
            end
            q_next[c] = sat_sum(acc);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                valid1_reg <= src_valid;
            end
            if (ready2)
            begin
                valid2_reg <= valid1_reg;
            end
            if (ready3)
            begin
                valid3_reg <= valid2_reg;
            end
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        if (ready1 && src_valid)
        begin
            prod_reg  <= prod_next;
            side1_reg <= src_side;
        end
        if (ready2 && valid1_reg)
        begin
            for (int i = 0; i < HAM_TERMS; i++)
            begin
                term_reg[i] <= round_sat(prod_reg[i]);
            end
            side2_reg <= side1_reg;
        end
        if (ready3 && valid2_reg)
        begin
            q_reg     <= q_next;
            side3_reg <= side2_reg;
        end
    end

    assign dst_valid = valid3_reg;
    assign dst_q     = q_reg;
    assign dst_side  = side3_reg;

endmodule

@@ rtl/core/quaternion_rotate_and_multiply.sv @@
// ----------------------------------------------------------------------------
// quaternion_rotate_and_multiply
// Signed fixed-point quaternion unit: Hamilton product of A and B, or
// rotation of the vector part of B by A.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_stall is low and gives one response
// per request, in order. Two three-stage product units sit in series
// (multiply, round, sum) followed by an output register: the first forms
// A*B, or A*(0,v) when rotating, and the second multiplies that by the
// conjugate of A; a plain product takes the first unit's result past the
// second. Every stage holds its contents under stall and empty stages keep
// filling, so the request side only stalls once the whole pipeline is full.
module quaternion_rotate_and_multiply (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  qrm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output qrm_pkg::rsp_t rsp
);
    import qrm_pkg::*;

    quat_t quat_a;
    quat_t quat_b;
    side_t side_in;

    logic  mid_valid;
    logic  mid_stall;
    quat_t mid_q;
    side_t mid_side;
    quat_t conj_a;
    side_t mid_side_out;

    logic  fin_valid;
    logic  fin_stall;
    quat_t fin_q;
    side_t fin_side;

    logic  rsp_valid_reg;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;
    logic  out_ready;

    // operands of the first product; rotation drops the scalar of B
    assign quat_a  = {req.a_z, req.a_y, req.a_x, req.a_w};
    assign quat_b  = (req.cmd == CMD_ROTATE) ? {req.b_z, req.b_y, req.b_x, {WORD_BITS{1'b0}}}
                                             : {req.b_z, req.b_y, req.b_x, req.b_w};
    assign side_in = '{cmd: req.cmd, q: quat_a};

    qrm_ham u_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (req_valid),
        .src_stall (req_stall),
        .src_a     (quat_a),
        .src_b     (quat_b),
        .src_side  (side_in),
        .dst_valid (mid_valid),
        .dst_stall (mid_stall),
        .dst_q     (mid_q),
        .dst_side  (mid_side)
    );

    // conjugate of A for the second product, first result rides along
    assign conj_a = {neg_sat(mid_side.q[3]), neg_sat(mid_side.q[2]),
                     neg_sat(mid_side.q[1]), mid_side.q[0]};
    assign mid_side_out = '{cmd: mid_side.cmd, q: mid_q};

    qrm_ham u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (mid_valid),
        .src_stall (mid_stall),
        .src_a     (mid_q),
        .src_b     (conj_a),
        .src_side  (mid_side_out),
        .dst_valid (fin_valid),
        .dst_stall (fin_stall),
        .dst_q     (fin_q),
        .dst_side  (fin_side)
    );

    // result select: rotation takes the second product
    always_comb
    begin
        if (fin_side.cmd == CMD_ROTATE)
        begin
            rsp_next = '{r_w: fin_q[0], r_x: fin_q[1], r_y: fin_q[2], r_z: fin_q[3]};
        end
        else
        begin
            rsp_next = '{r_w: fin_side.q[0], r_x: fin_side.q[1],
                         r_y: fin_side.q[2], r_z: fin_side.q[3]};
        end
    end

    assign out_ready = !rsp_valid_reg || !rsp_stall;
    assign fin_stall = !out_ready;

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            rsp_valid_reg <= fin_valid;
        end
    end

    // output register data
    always_ff @(posedge clk)
    begin
        if (out_ready && fin_valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/core/qrm_check.sv @@
// ----------------------------------------------------------------------------
// qrm_check
// Port-level checks for the quaternion unit: reset state, stall holding,
// backpressure only while the output is blocked, and fixed latency through
// a free-running pipeline. Bound to the top level below.
// ----------------------------------------------------------------------------
module qrm_check (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input qrm_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input qrm_pkg::rsp_t rsp
);
    import qrm_pkg::*;

    // nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !rsp_valid)
        else $error("response valid right after reset");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // requests are only held off while the output is blocked
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid || !rsp_stall) |-> !req_stall)
        else $error("request stalled with output free");

    // an accepted request reaches the output through all registers while the output flows freely
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
        ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
        else $error("response missing after pipeline latency");

endmodule

bind quaternion_rotate_and_multiply qrm_check u_check (.*);
